// ===== hdl/scene_text_lexer_defines.svh =====
// assertion macros for the scene text lexer checker
// depends on: nothing; expects i_clk and i_rst_n in the scope of use
`ifndef SCENE_TEXT_LEXER_DEFINES_SVH
`define SCENE_TEXT_LEXER_DEFINES_SVH

// same-cycle implication, quiet while reset is low
`define STL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is low
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/stl_pkg.sv =====
// shared types, character constants and byte classes for the scene text lexer
// depends on: nothing
package stl_pkg;

    // lexer mode, one-hot
    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_IDENT   = 7'b0000010,
        MODE_NUMBER  = 7'b0000100,
        MODE_PUNCT   = 7'b0001000,
        MODE_STRING  = 7'b0010000,
        MODE_QUOTE   = 7'b0100000,
        MODE_COMMENT = 7'b1000000
    } t_lex_mode;

    // token kind codes
    localparam logic [1:0] KIND_IDENT  = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_PUNCT  = 2'd2;
    localparam logic [1:0] KIND_STRING = 2'd3;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    // letters and underscore
    function automatic logic is_letter(input logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z)
            || (b == CH_UNDER);
    endfunction

    // digits and the marks that stay inside numbers and identifiers
    function automatic logic is_digit_mark(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || (b == CH_DOT) || (b == CH_SLASH)
            || (b == CH_DASH);
    endfunction

    // whitespace separators
    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_VT)
            || (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

// ===== hdl/scene_text_lexer.sv =====
// scene text lexer: byte-wise character-class tokenizer with line tracking
// depends on: stl_pkg
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid / o_in_ready, data, last flag  | byte in
//  out     | o_out_valid / i_out_ready, token fields   | result out
//
// one byte per cycle unless the output stalls: a byte is classified and the lexer
// state updated in the cycle of its transfer, and its result sits in the output
// register the next cycle. the output register takes a new result while the old
// one is transferred, so a stall on the output only holds the input for as long.
// synchronous active-low reset returns to idle with line count one; no clearing pass.
module scene_text_lexer #(
    parameter int LINE_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_has_char,
    output logic [7:0]           o_char_out,
    output logic [1:0]           o_token_kind,
    output logic                 o_token_start,
    output logic [LINE_BITS-1:0] o_line_number,
    output logic                 o_stream_end
);

    localparam logic [LINE_BITS-1:0] LineOne = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LineMax = {LINE_BITS{1'b1}};

    // lexer state
    stl_pkg::t_lex_mode   r_mode, n_mode;
    logic [7:0]           r_run, n_run;
    logic [LINE_BITS-1:0] r_line_cnt, n_line_cnt;
    logic [LINE_BITS-1:0] r_tok_line, n_tok_line;

    // output register
    logic                 r_out_valid;
    logic                 r_has_char;
    logic [7:0]           r_char;
    logic [1:0]           r_kind;
    logic                 r_start;
    logic [LINE_BITS-1:0] r_line;
    logic                 r_end;

    // result of the current byte
    logic                 emit;
    logic [1:0]           kind;
    logic                 start;
    logic                 fresh;
    logic [LINE_BITS-1:0] line_res;
    logic                 in_xfer;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // classify the byte against the current mode
    always_comb begin
        n_mode     = r_mode;
        n_run      = r_run;
        n_line_cnt = r_line_cnt;
        n_tok_line = r_tok_line;
        emit       = 1'b0;
        kind       = stl_pkg::KIND_IDENT;
        start      = 1'b0;
        fresh      = 1'b0;

        unique case (r_mode)
            stl_pkg::MODE_IDENT: begin
                if (stl_pkg::is_letter(i_data_byte) || stl_pkg::is_digit_mark(i_data_byte)) begin
                    emit = 1'b1;
                    kind = stl_pkg::KIND_IDENT;
                end else begin
                    fresh = 1'b1;
                end
            end
            stl_pkg::MODE_NUMBER: begin
                if (stl_pkg::is_digit_mark(i_data_byte)) begin
                    emit = 1'b1;
                    kind = stl_pkg::KIND_NUMBER;
                end else begin
                    fresh = 1'b1;
                end
            end
            stl_pkg::MODE_PUNCT: begin
                if (i_data_byte == r_run) begin
                    emit = 1'b1;
                    kind = stl_pkg::KIND_PUNCT;
                end else begin
                    fresh = 1'b1;
                end
            end
            stl_pkg::MODE_STRING: begin
                if (i_data_byte == stl_pkg::CH_QUOTE) begin
                    n_mode = stl_pkg::MODE_QUOTE;
                end else begin
                    emit  = 1'b1;
                    kind  = stl_pkg::KIND_STRING;
                    start = (r_run == 8'd0);
                    n_run = 8'd1;
                end
            end
            stl_pkg::MODE_QUOTE: begin
                // doubled quote gives a literal quote
                if (i_data_byte == stl_pkg::CH_QUOTE) begin
                    emit   = 1'b1;
                    kind   = stl_pkg::KIND_STRING;
                    start  = (r_run == 8'd0);
                    n_run  = 8'd1;
                    n_mode = stl_pkg::MODE_STRING;
                end else begin
                    fresh = 1'b1;
                end
            end
            stl_pkg::MODE_COMMENT: begin
                if (i_data_byte == stl_pkg::CH_NL) begin
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // byte lexed from scratch
        if (fresh) begin
            priority if (stl_pkg::is_blank(i_data_byte)) begin
                n_mode = stl_pkg::MODE_IDLE;
                if (i_data_byte == stl_pkg::CH_NL && r_line_cnt != LineMax) begin
                    n_line_cnt = r_line_cnt + LineOne;
                end
            end else if (i_data_byte == stl_pkg::CH_QUOTE) begin
                n_mode     = stl_pkg::MODE_STRING;
                n_run      = 8'd0;
                n_tok_line = r_line_cnt;
            end else if (i_data_byte == stl_pkg::CH_HASH) begin
                n_mode = stl_pkg::MODE_COMMENT;
            end else if (stl_pkg::is_letter(i_data_byte)) begin
                n_mode     = stl_pkg::MODE_IDENT;
                n_tok_line = r_line_cnt;
                emit       = 1'b1;
                kind       = stl_pkg::KIND_IDENT;
                start      = 1'b1;
            end else if (stl_pkg::is_digit_mark(i_data_byte)) begin
                n_mode     = stl_pkg::MODE_NUMBER;
                n_tok_line = r_line_cnt;
                emit       = 1'b1;
                kind       = stl_pkg::KIND_NUMBER;
                start      = 1'b1;
            end else begin
                n_mode     = stl_pkg::MODE_PUNCT;
                n_run      = i_data_byte;
                n_tok_line = r_line_cnt;
                emit       = 1'b1;
                kind       = stl_pkg::KIND_PUNCT;
                start      = 1'b1;
            end
        end

        // token line while emitting, updated line count otherwise
        line_res = emit ? n_tok_line : n_line_cnt;

        // end of text returns the lexer state to reset values
        if (i_last_byte) begin
            n_mode     = stl_pkg::MODE_IDLE;
            n_run      = 8'd0;
            n_line_cnt = LineOne;
            n_tok_line = LineOne;
        end
    end

    // lexer state update on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= stl_pkg::MODE_IDLE;
            r_run      <= 8'd0;
            r_line_cnt <= LineOne;
            r_tok_line <= LineOne;
        end else if (in_xfer) begin
            r_mode     <= n_mode;
            r_run      <= n_run;
            r_line_cnt <= n_line_cnt;
            r_tok_line <= n_tok_line;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_has_char <= emit;
            r_char     <= emit ? i_data_byte : 8'd0;
            r_kind     <= emit ? kind : stl_pkg::KIND_IDENT;
            r_start    <= emit && start;
            r_line     <= line_res;
            r_end      <= i_last_byte;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_has_char    = r_has_char;
    assign o_char_out    = r_char;
    assign o_token_kind  = r_kind;
    assign o_token_start = r_start;
    assign o_line_number = r_line;
    assign o_stream_end  = r_end;

endmodule

// ===== hdl/stl_checker.sv =====
// port-level checks for the scene text lexer, bound to the top level
// depends on: stl_pkg, scene_text_lexer_defines.svh
`include "scene_text_lexer_defines.svh"

module stl_checker #(
    parameter int LINE_BITS = 20
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [7:0]           i_data_byte,
    input logic                 i_last_byte,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_has_char,
    input logic [7:0]           o_char_out,
    input logic [1:0]           o_token_kind,
    input logic                 o_token_start,
    input logic [LINE_BITS-1:0] o_line_number,
    input logic                 o_stream_end
);

    logic [7:0]          r_in_data;
    logic                r_in_last;
    logic                fields_zero;
    logic                out_stall;
    logic                echo_ok;
    logic [LINE_BITS+12:0] out_word;

    // last transferred input byte, compared with the result it produced
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // short terms for the checks below
    assign fields_zero = (o_char_out == 8'd0) && (o_token_kind == stl_pkg::KIND_IDENT)
                         && !o_token_start;
    assign out_stall   = o_out_valid && !i_out_ready;
    assign echo_ok     = (o_stream_end == r_in_last) && (!o_has_char || o_char_out == r_in_data);
    assign out_word    = {o_has_char, o_char_out, o_token_kind, o_token_start, o_line_number,
                          o_stream_end};

    // a result without a character carries zero fields
    `STL_ASSERT_NOW(a_blank_zero, o_out_valid && !o_has_char, fields_zero, "stray character fields")

    // a token start always comes with a character
    `STL_ASSERT_NOW(a_start_char, o_out_valid && o_token_start, o_has_char, "start without a character")

    // line numbers count from one
    `STL_ASSERT_NOW(a_line_nonzero, o_out_valid, o_line_number != '0, "line number is zero")

    // a stalled result holds
    `STL_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(out_word), "held result changed")

    // the result echoes the end flag and character of its byte
    `STL_ASSERT_NOW(a_in_echo, o_out_valid, echo_ok, "result does not match its byte")

endmodule

bind scene_text_lexer stl_checker #(.LINE_BITS(LINE_BITS)) u_stl_checker (.*);
